[rtl/core/dq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared types and codes for the double-ended queue
// Request and response beats, operation and status codes, and the control
// bundle that the top level broadcasts along the row of cells.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int WORD_W = 32;
	localparam int OP_W   = 3;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
	localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
	localparam logic [OP_W-1:0] OP_PEEK_REAR  = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd2;

	localparam logic signed [WORD_W-1:0] WORD_EMPTY = -32'sd1;

	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic signed [WORD_W-1:0] push_value;
	} dq_req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] result_value;
		logic [STAT_W-1:0]        status;
		logic [OCC_W-1:0]         occupancy;
	} dq_rsp_t;

	// One-cycle command to every cell; at most one of the four flags is set
	typedef struct packed {
		logic                     push_front;
		logic                     pop_front;
		logic                     push_rear;
		logic                     pop_rear;
		logic signed [WORD_W-1:0] word;
	} dq_ctrl_t;

endpackage

[rtl/core/dq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cell: one slot of the deque row
// Holds one word and its valid flag; shifts towards or away from the front
// on front pushes and pops, and takes or drops the word at the rear end.
// ----------------------------------------------------------------------------
module dq_cell
	import dq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  dq_ctrl_t                 ctrl,
	input  logic                     prev_valid,
	input  logic signed [WORD_W-1:0] prev_word,
	input  logic                     next_valid,
	input  logic signed [WORD_W-1:0] next_word,
	output logic                     valid,
	output logic signed [WORD_W-1:0] word,
	output logic                     is_last
);

	logic                     valid_q;
	logic signed [WORD_W-1:0] word_q;
	logic                     rear_slot;

	// first empty slot behind the occupied run
	assign rear_slot = !valid_q && prev_valid;
	assign is_last   = valid_q && !next_valid;
	assign valid     = valid_q;
	assign word      = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			priority if (ctrl.push_front) begin
				valid_q <= prev_valid;
			end else if (ctrl.pop_front) begin
				valid_q <= next_valid;
			end else if (ctrl.push_rear && rear_slot) begin
				valid_q <= 1'b1;
			end else if (ctrl.pop_rear && is_last) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctrl.push_front) begin
			word_q <= prev_word;
		end else if (ctrl.pop_front) begin
			word_q <= next_word;
		end else if (ctrl.push_rear && rear_slot) begin
			word_q <= ctrl.word;
		end
	end

endmodule

[rtl/core/double_ended_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit words
// A row of DEPTH cells with the front word always in cell 0; every request
// beat returns exactly one response beat with value, status and occupancy.
// ----------------------------------------------------------------------------
// The deque accepts one request beat per cycle while req_stall is low and
// answers each with one response beat in the next cycle, held in an output
// register; a new request is taken while the previous response is still
// waiting, as long as that response is taken in the same cycle. Words sit in
// a row of DEPTH cells with the front word in cell 0 and the rear word in the
// last valid cell: a push or pop at the front shifts the whole row by one
// place, a push at the rear fills the first empty cell, and a pop at the rear
// clears the last valid one. Peeks read cell 0 or the last valid cell. A pop
// or peek on an empty deque answers underflow with -1; a push on a full deque
// answers overflow and changes nothing. Operation codes 6 and 7 change nothing
// and answer ok with value 0. Occupancy is the count after the operation, in
// five bits. No clearing pass is needed after reset: the cell valid flags
// clear at once.
// ----------------------------------------------------------------------------
module double_ended_queue
	import dq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_stall,
	input  dq_req_t req,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	output dq_rsp_t rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	// row of cells
	logic                     cell_valid [DEPTH];
	logic signed [WORD_W-1:0] cell_word  [DEPTH];
	logic                     cell_last  [DEPTH];

	// control and bookkeeping
	logic                     take;
	logic                     empty;
	logic                     full;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         cnt_next;
	logic signed [WORD_W-1:0] rear_word;
	dq_ctrl_t                 ctrl;
	dq_rsp_t                  rsp_next;
	dq_rsp_t                  rsp_q;
	logic                     rsp_valid_q;

	// Hold the request while a finished beat waits and the far side stalls
	assign req_stall = rsp_valid_q && rsp_stall;
	assign take      = req_valid && !req_stall;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_FULL);

	// Gather the rear word: exactly one cell flags itself last when not empty
	always_comb begin
		rear_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_word = rear_word | (cell_word[i] & {WORD_W{cell_last[i]}});
		end
	end

	// Decode the request into a row command and a response beat
	always_comb begin
		ctrl                  = '0;
		ctrl.word             = req.push_value;
		cnt_next              = cnt_q;
		rsp_next.result_value = '0;
		rsp_next.status       = STAT_OK;
		unique case (req.operation)
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (full) begin
					rsp_next.status = STAT_OVERFLOW;
				end else begin
					ctrl.push_front = take && (req.operation == OP_PUSH_FRONT);
					ctrl.push_rear  = take && (req.operation == OP_PUSH_REAR);
					cnt_next        = cnt_q + CNT_ONE;
				end
			end
			OP_POP_FRONT, OP_PEEK_FRONT: begin
				if (empty) begin
					rsp_next.status       = STAT_UNDERFLOW;
					rsp_next.result_value = WORD_EMPTY;
				end else begin
					rsp_next.result_value = cell_word[0];
					if (req.operation == OP_POP_FRONT) begin
						ctrl.pop_front = take;
						cnt_next       = cnt_q - CNT_ONE;
					end
				end
			end
			OP_POP_REAR, OP_PEEK_REAR: begin
				if (empty) begin
					rsp_next.status       = STAT_UNDERFLOW;
					rsp_next.result_value = WORD_EMPTY;
				end else begin
					rsp_next.result_value = rear_word;
					if (req.operation == OP_POP_REAR) begin
						ctrl.pop_rear = take;
						cnt_next      = cnt_q - CNT_ONE;
					end
				end
			end
			default: begin
				// unused codes: answer ok, change nothing
			end
		endcase
		rsp_next.occupancy = OCC_W'(cnt_next);
	end

	// Advance the count only on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			cnt_q <= cnt_next;
		end
	end

	// Output register: load on accept, drop the flag once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The row: cell 0 takes the pushed word from the front, the last cell
	// sees an empty neighbour behind it
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                     prev_valid;
		logic signed [WORD_W-1:0] prev_word;
		logic                     next_valid;
		logic signed [WORD_W-1:0] next_word;

		if (i == 0) begin : g_head
			assign prev_valid = 1'b1;
			assign prev_word  = req.push_value;
		end else begin : g_body
			assign prev_valid = cell_valid[i-1];
			assign prev_word  = cell_word[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_valid = 1'b0;
			assign next_word  = '0;
		end else begin : g_inner
			assign next_valid = cell_valid[i+1];
			assign next_word  = cell_word[i+1];
		end

		dq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_valid (prev_valid),
			.prev_word  (prev_word),
			.next_valid (next_valid),
			.next_word  (next_word),
			.valid      (cell_valid[i]),
			.word       (cell_word[i]),
			.is_last    (cell_last[i])
		);
	end

endmodule
